@@ hw/rtl/plbt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package plbt_pkg;

  localparam int LEVELS_PER_SIDE = 256;
  localparam int IDX_W = $clog2(LEVELS_PER_SIDE);
  localparam int CNT_W = IDX_W + 1;
  localparam int ADDR_W = IDX_W + 1;
  localparam int PRICE_W = 32;
  localparam int QTY_W = 32;
  localparam int MKT_W = 32;
  localparam int ENTRY_W = PRICE_W + QTY_W;
  localparam int TABLE_DEPTH = 2 * LEVELS_PER_SIDE;

  typedef logic [1:0] status_t;
  localparam status_t ST_APPLIED = 2'd0;
  localparam status_t ST_REJECT  = 2'd1;
  localparam status_t ST_FULL    = 2'd2;

  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  typedef struct packed {
    logic    idle;
    logic    rd_en;
    logic    slot_hit;
    logic    slot_new;
    logic    wr_en;
    logic    cnt_clr;
    logic    scan;
    logic    scan_fin;
    logic    stat_we;
    status_t stat;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic accept;
    logic reject;
    logic hit;
    logic more;
    logic pend;
    logic full;
    logic need_scan;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/plbt_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface plbt_upd_if;
  logic                          valid;
  logic                          ready;
  logic                          side;
  logic [plbt_pkg::PRICE_W-1:0]  price;
  logic [plbt_pkg::QTY_W-1:0]    quantity;
  logic [plbt_pkg::MKT_W-1:0]    market;
  modport source (output valid, side, price, quantity, market, input ready);
  modport sink (input valid, side, price, quantity, market, output ready);
endinterface

interface plbt_res_if;
  logic                          valid;
  logic                          ready;
  plbt_pkg::status_t             status;
  logic [plbt_pkg::PRICE_W-1:0]  best_bid_price;
  logic                          best_bid_present;
  logic [plbt_pkg::PRICE_W-1:0]  best_ask_price;
  logic                          best_ask_present;
  logic                          book_uncrossed;
  modport source (output valid, status, best_bid_price, best_bid_present, best_ask_price,
                  best_ask_present, book_uncrossed, input ready);
  modport sink (input valid, status, best_bid_price, best_bid_present, best_ask_price,
                best_ask_present, book_uncrossed, output ready);
endinterface

interface plbt_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [plbt_pkg::MKT_W-1:0]    data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/plbt_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module plbt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/plbt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module plbt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire plbt_pkg::sts_t sts,
  output plbt_pkg::cmd_t      cmd
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MATCH = 5'b00010,
    S_WRITE = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.stat = plbt_pkg::ST_APPLIED;
    unique case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (sts.accept) begin
          state_next = S_MATCH;
        end
      end
      S_MATCH: begin
        priority if (sts.reject) begin
          cmd.stat_we = 1'b1;
          cmd.stat = plbt_pkg::ST_REJECT;
          state_next = S_DONE;
        end else if (sts.hit) begin
          cmd.slot_hit = 1'b1;
          state_next = S_WRITE;
        end else if (sts.more) begin
          cmd.rd_en = 1'b1;
        end else if (sts.pend) begin
          // last read still in flight
        end else if (sts.full) begin
          cmd.stat_we = 1'b1;
          cmd.stat = plbt_pkg::ST_FULL;
          state_next = S_DONE;
        end else begin
          cmd.slot_new = 1'b1;
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.wr_en = 1'b1;
        cmd.stat_we = 1'b1;
        cmd.stat = plbt_pkg::ST_APPLIED;
        if (sts.need_scan) begin
          cmd.cnt_clr = 1'b1;
          state_next = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.more) begin
          cmd.rd_en = 1'b1;
        end else if (!sts.pend) begin
          cmd.scan_fin = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

@@ hw/rtl/plbt_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module plbt_dp (
  input  wire logic           clk,
  input  wire logic           rst,
  plbt_upd_if.sink            upd,
  plbt_res_if.source          res,
  plbt_cfg_if.sink            cfg,
  input  wire plbt_pkg::cmd_t cmd,
  output plbt_pkg::sts_t      sts
);
  logic [plbt_pkg::MKT_W-1:0]   filter;
  logic                         it_side;
  logic [plbt_pkg::PRICE_W-1:0] it_price;
  logic [plbt_pkg::QTY_W-1:0]   it_qty;
  logic                         reject;
  logic [plbt_pkg::CNT_W-1:0]   cnt;
  logic                         rd_pend;
  logic [plbt_pkg::IDX_W-1:0]   rd_idx;
  logic [plbt_pkg::IDX_W-1:0]   slot;
  logic                         is_new;
  logic [plbt_pkg::CNT_W-1:0]   fill_bid, fill_ask, fill_cur;
  logic [plbt_pkg::PRICE_W-1:0] best_bid, best_ask, cur_best, acc;
  logic                         bid_v, ask_v, cur_v, found;
  plbt_pkg::status_t            stat;
  logic                         accept;
  logic [plbt_pkg::ENTRY_W-1:0] rdata;
  logic [plbt_pkg::PRICE_W-1:0] rd_price;
  logic [plbt_pkg::QTY_W-1:0]   rd_qty;
  logic                         new_better, rd_better;
  logic                         out_valid;

  assign cfg.ready = 1'b1;
  assign upd.ready = cmd.idle;
  assign accept = upd.valid && cmd.idle;

  assign fill_cur = it_side ? fill_ask : fill_bid;
  assign cur_best = it_side ? best_ask : best_bid;
  assign cur_v = it_side ? ask_v : bid_v;
  assign rd_price = rdata[plbt_pkg::ENTRY_W-1:plbt_pkg::QTY_W];
  assign rd_qty = rdata[plbt_pkg::QTY_W-1:0];
  // asks improve downward, bids upward
  assign new_better = it_side ? (it_price < cur_best) : (it_price > cur_best);
  assign rd_better = it_side ? (rd_price < acc) : (rd_price > acc);

  plbt_ram #(
    .WIDTH(plbt_pkg::ENTRY_W),
    .DEPTH(plbt_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .wr_en (cmd.wr_en),
    .waddr ({it_side, slot}),
    .wdata ({it_price, it_qty}),
    .rd_en (cmd.rd_en),
    .raddr ({it_side, cnt[plbt_pkg::IDX_W-1:0]}),
    .rdata (rdata)
  );

  always_comb begin
    sts.accept = accept;
    sts.reject = reject;
    sts.hit = rd_pend && (rd_price == it_price);
    sts.more = cnt < fill_cur;
    sts.pend = rd_pend;
    sts.full = fill_cur == plbt_pkg::CNT_W'(plbt_pkg::LEVELS_PER_SIDE);
    sts.need_scan = (it_qty == '0) && cur_v && (it_price == cur_best);
    sts.out_free = !out_valid || res.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter <= '0;
      fill_bid <= '0;
      fill_ask <= '0;
      best_bid <= '0;
      best_ask <= '0;
      bid_v <= 1'b0;
      ask_v <= 1'b0;
      rd_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        filter <= cfg.data;
      end
      rd_pend <= cmd.rd_en;
      if (cmd.wr_en) begin
        if (is_new) begin
          if (it_side == plbt_pkg::SIDE_ASK) begin
            fill_ask <= fill_ask + 1'b1;
          end else begin
            fill_bid <= fill_bid + 1'b1;
          end
        end
        if ((it_qty != '0) && (!cur_v || new_better)) begin
          if (it_side == plbt_pkg::SIDE_ASK) begin
            best_ask <= it_price;
            ask_v <= 1'b1;
          end else begin
            best_bid <= it_price;
            bid_v <= 1'b1;
          end
        end
      end
      // no nonzero level left keeps the old best
      if (cmd.scan_fin && found) begin
        if (it_side == plbt_pkg::SIDE_ASK) begin
          best_ask <= acc;
        end else begin
          best_bid <= acc;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it_side <= upd.side;
      it_price <= upd.price;
      it_qty <= upd.quantity;
      reject <= (filter != '0) && (filter != upd.market);
    end
    if (accept || cmd.cnt_clr) begin
      cnt <= '0;
      found <= 1'b0;
    end else if (cmd.rd_en) begin
      cnt <= cnt + 1'b1;
    end
    if (cmd.rd_en) begin
      rd_idx <= cnt[plbt_pkg::IDX_W-1:0];
    end
    if (cmd.slot_hit) begin
      slot <= rd_idx;
      is_new <= 1'b0;
    end else if (cmd.slot_new) begin
      slot <= fill_cur[plbt_pkg::IDX_W-1:0];
      is_new <= 1'b1;
    end
    if (cmd.scan && rd_pend && (rd_qty != '0) && (!found || rd_better)) begin
      acc <= rd_price;
      found <= 1'b1;
    end
    if (cmd.stat_we) begin
      stat <= cmd.stat;
    end
    if (cmd.out_load) begin
      res.status <= stat;
      res.best_bid_price <= best_bid;
      res.best_bid_present <= bid_v;
      res.best_ask_price <= best_ask;
      res.best_ask_present <= ask_v;
      res.book_uncrossed <= !bid_v || !ask_v || (best_bid < best_ask);
    end
  end

  assign res.valid = out_valid;
endmodule
`default_nettype wire

@@ hw/rtl/price_level_book_top_tracker_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Price-level book top tracker. Each update item is matched against the stored levels of its
// side by reading the level table one entry a cycle, up to n entries, n being the number of
// distinct prices stored on that side; a zero quantity at the best price adds a second pass
// over the table, and a market mismatch skips the table. The level table has one read port and
// one write port. A finished result sits in an output register, so the next item is taken
// while it waits; a second result that finds the register still full holds its item until
// the receiver takes the first. The market filter can be written at any idle time; no
// clearing pass is needed after reset.
module price_level_book_top_tracker_unit (
  input wire logic clk,
  input wire logic rst,
  plbt_upd_if.sink   upd,
  plbt_res_if.source res,
  plbt_cfg_if.sink   cfg
);
  plbt_pkg::cmd_t cmd;
  plbt_pkg::sts_t sts;

  plbt_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  plbt_dp u_dp (
    .clk (clk),
    .rst (rst),
    .upd (upd),
    .res (res),
    .cfg (cfg),
    .cmd (cmd),
    .sts (sts)
  );
endmodule
`default_nettype wire

@@ hw/rtl/plbt_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
module plbt_chk (
  input wire logic clk,
  input wire logic rst,
  input wire logic res_valid,
  input wire logic res_ready,
  input wire logic res_bid_present,
  input wire logic res_ask_present,
  input wire logic res_uncrossed,
  input wire logic [plbt_pkg::PRICE_W-1:0] res_bid,
  input wire logic [plbt_pkg::PRICE_W-1:0] res_ask
);
  logic seen_bid;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_bid <= 1'b0;
    end else if (res_valid && res_bid_present) begin
      seen_bid <= 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_bid_sticky: assert property (@(posedge clk) disable iff (rst)
    res_valid && seen_bid |-> res_bid_present)
    else $error("best bid lost its present flag");

  a_uncrossed: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_uncrossed == (!res_bid_present || !res_ask_present || (res_bid < res_ask)))
    else $error("uncrossed flag disagrees with bests");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");
endmodule

bind price_level_book_top_tracker_unit plbt_chk u_chk (
  .clk             (clk),
  .rst             (rst),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .res_bid_present (res.best_bid_present),
  .res_ask_present (res.best_ask_present),
  .res_uncrossed   (res.book_uncrossed),
  .res_bid         (res.best_bid_price),
  .res_ask         (res.best_ask_price)
);
`default_nettype wire

@@ bench/plbt_tb_if.sv @@
`timescale 1ns / 1ps
// channel interfaces come from the rtl interface file; this file holds the bench-side
// monitor bundle that the checker reads, so the checker sees plain signals
interface plbt_mon_if;
  logic upd_fire;
  logic res_fire;
  logic cfg_fire;
  logic [31:0] cfg_data;
  logic upd_side;
  logic [31:0] upd_price;
  logic [31:0] upd_qty;
  logic [31:0] upd_market;
  logic [1:0] res_status;
  logic [31:0] res_bid;
  logic res_bid_ok;
  logic [31:0] res_ask;
  logic res_ask_ok;
  logic res_uncrossed;
  modport source (output upd_fire, res_fire, cfg_fire, cfg_data, upd_side, upd_price,
                  upd_qty, upd_market, res_status, res_bid, res_bid_ok, res_ask, res_ask_ok,
                  res_uncrossed);
  modport sink (input upd_fire, res_fire, cfg_fire, cfg_data, upd_side, upd_price,
                upd_qty, upd_market, res_status, res_bid, res_bid_ok, res_ask, res_ask_ok,
                res_uncrossed);
endinterface

@@ bench/plbt_book_checker.sv @@
`timescale 1ns / 1ps
module plbt_book_checker
  import plbt_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  plbt_mon_if.sink mon,
  output int errors,
  output int pending,
  output int results_seen,
  output int full_seen,
  output int reject_seen,
  output int rescan_seen
);

  typedef struct packed {
    status_t     status;
    logic [31:0] bid;
    logic        bid_ok;
    logic [31:0] ask;
    logic        ask_ok;
    logic        uncrossed;
  } book_top_t;

  logic [31:0] lvl_price [2][LEVELS_PER_SIDE];
  logic [31:0] lvl_qty [2][LEVELS_PER_SIDE];
  logic        lvl_used [2][LEVELS_PER_SIDE];
  logic [31:0] best_px [2];
  logic        best_ok [2];
  logic [31:0] filter;
  book_top_t   expected_tops [$];

  function automatic book_top_t apply_update(logic sd, logic [31:0] px, logic [31:0] qty,
                                             logic [31:0] mkt);
    book_top_t t;
    int slot;
    int free_slot;
    logic found;
    logic [31:0] b;
    free_slot = -1;
    slot = -1;
    t.status = ST_APPLIED;
    if (filter != 0 && filter != mkt) begin
      t.status = ST_REJECT;
      reject_seen++;
    end else begin
      for (int i = 0; i < LEVELS_PER_SIDE; i++) begin
        if (lvl_used[sd][i]) begin
          if (slot < 0 && lvl_price[sd][i] == px) slot = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (slot < 0) slot = free_slot;
      if (slot < 0) begin
        t.status = ST_FULL;
        full_seen++;
      end else begin
        lvl_price[sd][slot] = px;
        lvl_qty[sd][slot] = qty;
        lvl_used[sd][slot] = 1'b1;
        if (qty != 0) begin
          if (!best_ok[sd] || (sd == SIDE_ASK ? px < best_px[sd] : px > best_px[sd])) begin
            best_px[sd] = px;
            best_ok[sd] = 1'b1;
          end
        end else if (best_ok[sd] && px == best_px[sd]) begin
          // rescan for best remaining nonzero level; keep old best if none
          found = 1'b0;
          b = '0;
          rescan_seen++;
          for (int i = 0; i < LEVELS_PER_SIDE; i++) begin
            if (lvl_used[sd][i] && lvl_qty[sd][i] != 0) begin
              if (!found || (sd == SIDE_BID ? lvl_price[sd][i] > b : lvl_price[sd][i] < b))
                begin
                b = lvl_price[sd][i];
                found = 1'b1;
              end
            end
          end
          if (found) best_px[sd] = b;
        end
      end
    end
    t.bid = best_px[SIDE_BID];
    t.bid_ok = best_ok[SIDE_BID];
    t.ask = best_px[SIDE_ASK];
    t.ask_ok = best_ok[SIDE_ASK];
    t.uncrossed = !best_ok[SIDE_BID] || !best_ok[SIDE_ASK] ||
                  (best_px[SIDE_BID] < best_px[SIDE_ASK]);
    return t;
  endfunction

  always @(posedge clk) begin
    book_top_t got;
    book_top_t exp_top;
    if (rst) begin
      filter <= '0;
      for (int s = 0; s < 2; s++) begin
        best_px[s] = '0;
        best_ok[s] = 1'b0;
        for (int i = 0; i < LEVELS_PER_SIDE; i++) lvl_used[s][i] = 1'b0;
      end
      expected_tops.delete();
    end else begin
      if (mon.cfg_fire) filter <= mon.cfg_data;
      if (mon.upd_fire)
        expected_tops.push_back(apply_update(mon.upd_side, mon.upd_price, mon.upd_qty,
                                             mon.upd_market));
      if (mon.res_fire) begin
        got.status = mon.res_status;
        got.bid = mon.res_bid;
        got.bid_ok = mon.res_bid_ok;
        got.ask = mon.res_ask;
        got.ask_ok = mon.res_ask_ok;
        got.uncrossed = mon.res_uncrossed;
        results_seen++;
        if (expected_tops.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result item: %p", got);
        end else begin
          exp_top = expected_tops.pop_front();
          if (got !== exp_top) begin
            errors++;
            if (errors <= 10)
              $display("mismatch at result %0d\n  expected %p\n  actual   %p",
                       results_seen, exp_top, got);
          end
        end
      end
    end
    pending = expected_tops.size();
  end

  initial begin
    errors = 0;
    pending = 0;
    results_seen = 0;
    full_seen = 0;
    reject_seen = 0;
    rescan_seen = 0;
  end

endmodule

@@ bench/price_level_book_top_tracker_unit_tb.sv @@
`timescale 1ns / 1ps
module price_level_book_top_tracker_unit_tb;
  import plbt_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  logic clk;
  logic rst;
  int   cycles;
  int   errors;
  int   pending;
  int   results_seen;
  int   full_seen;
  int   reject_seen;
  int   rescan_seen;
  int   stall_mode;
  logic [31:0] cur_filter;
  logic [31:0] price_pool [16];

  plbt_upd_if upd ();
  plbt_res_if res ();
  plbt_cfg_if cfg ();
  plbt_mon_if mon ();

  price_level_book_top_tracker_unit dut (
    .clk(clk),
    .rst(rst),
    .upd(upd.sink),
    .res(res.source),
    .cfg(cfg.sink)
  );

  assign mon.upd_fire = upd.valid && upd.ready;
  assign mon.res_fire = res.valid && res.ready;
  assign mon.cfg_fire = cfg.valid && cfg.ready;
  assign mon.cfg_data = cfg.data;
  assign mon.upd_side = upd.side;
  assign mon.upd_price = upd.price;
  assign mon.upd_qty = upd.quantity;
  assign mon.upd_market = upd.market;
  assign mon.res_status = res.status;
  assign mon.res_bid = res.best_bid_price;
  assign mon.res_bid_ok = res.best_bid_present;
  assign mon.res_ask = res.best_ask_price;
  assign mon.res_ask_ok = res.best_ask_present;
  assign mon.res_uncrossed = res.book_uncrossed;

  plbt_book_checker chk (
    .clk(clk),
    .rst(rst),
    .mon(mon.sink),
    .errors(errors),
    .pending(pending),
    .results_seen(results_seen),
    .full_seen(full_seen),
    .reject_seen(reject_seen),
    .rescan_seen(rescan_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver stall pattern, mode changes per phase
  always @(negedge clk) begin
    case (stall_mode)
      0: res.ready <= 1'b1;
      1: res.ready <= ($urandom_range(0, 3) != 0);
      2: res.ready <= (cycles % 7) < 3;
      default: res.ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  task automatic send_update(logic sd, logic [31:0] px, logic [31:0] qty, logic [31:0] mkt);
    upd.valid <= 1'b1;
    upd.side <= sd;
    upd.price <= px;
    upd.quantity <= qty;
    upd.market <= mkt;
    @(posedge clk);
    while (!upd.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    upd.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain_book;
    upd.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    // every result has been taken once pending is zero; this wait only adds idle time
    repeat (600) @(negedge clk);
  endtask

  task automatic write_filter(logic [31:0] v);
    cfg.valid <= 1'b1;
    cfg.data <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
    cur_filter = v;
  endtask

  function automatic logic [31:0] pick_market();
    if (cur_filter != 0 && $urandom_range(0, 4) != 0) return cur_filter;
    return $urandom();
  endfunction

  // random bursts of book traffic over a small price pool so levels repeat
  task automatic random_phase(int items, int depth);
    int burst;
    int sent;
    logic [31:0] px;
    logic [31:0] qty;
    sent = 0;
    for (int i = 0; i < 16; i++) price_pool[i] = $urandom();
    while (sent < items) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < items; k++) begin
        case ($urandom_range(0, 5))
          0: px = $urandom();
          1: px = $urandom_range(0, depth);
          default: px = price_pool[$urandom_range(0, 15)];
        endcase
        qty = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom();
        send_update($urandom_range(0, 1), px, qty, pick_market());
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
    end
  endtask

  initial begin
    cycles = 0;
    stall_mode = 0;
    cur_filter = '0;
    rst = 1'b1;
    upd.valid = 1'b0;
    upd.side = 1'b0;
    upd.price = '0;
    upd.quantity = '0;
    upd.market = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, zero qty with no best, clearing best with and without rescan
    send_update(SIDE_BID, 32'd0, 32'd5, 32'd0);
    send_update(SIDE_ASK, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_update(SIDE_ASK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
    send_update(SIDE_BID, 32'd100, 32'd1, 32'd7);
    send_update(SIDE_BID, 32'd90, 32'd2, 32'd7);
    send_update(SIDE_BID, 32'd100, 32'd0, 32'd7);
    send_update(SIDE_BID, 32'd90, 32'd0, 32'd7);
    send_update(SIDE_BID, 32'd0, 32'd0, 32'd7);
    send_update(SIDE_ASK, 32'd50, 32'd3, 32'd7);
    send_update(SIDE_BID, 32'd60, 32'd3, 32'd7);
    send_update(SIDE_ASK, 32'd50, 32'd0, 32'd7);
    send_update(SIDE_ASK, 32'hAAAA_5555, 32'h5555_AAAA, 32'hAAAA_5555);
    drain_book();
    write_filter(32'd7);
    stall_mode = 1;
    send_update(SIDE_BID, 32'd200, 32'd1, 32'd8);
    send_update(SIDE_BID, 32'd200, 32'd1, 32'd7);
    send_update(SIDE_ASK, 32'd10, 32'd1, 32'hFFFF_FFFF);
    drain_book();
    write_filter(32'hFFFF_FFFF);
    random_phase(150, 300);
    drain_book();
    write_filter(32'd0);
    stall_mode = 2;

    // fill the bid side to force table full drops
    for (int i = 0; i < LEVELS_PER_SIDE + 4; i++)
      send_update(SIDE_BID, 32'h1000 + i, (i % 3 == 0) ? 32'd0 : i, $urandom());
    send_update(SIDE_BID, 32'h1000 + 3, 32'd9, 32'd0);
    send_update(SIDE_BID, 32'h1000 + LEVELS_PER_SIDE - 2, 32'd0, 32'd0);
    drain_book();
    stall_mode = 0;
    random_phase(400, 300);
    drain_book();
    write_filter(32'h0000_0001);
    stall_mode = 3;
    random_phase(200, 300);
    drain_book();
    write_filter(32'd0);
    stall_mode = 1;
    random_phase(400, 300);
    drain_book();

    $display("checked %0d result items: %0d rejected, %0d full drops, %0d best clears",
             results_seen, reject_seen, full_seen, rescan_seen);
    $display("filter settings zero, small, all ones; four receiver stall patterns");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
